// ===== rtl/ilce_pkg.sv =====
// ----------------------------------------------------------------------------
// ilce_pkg: shared types and constants of the IPv4 / layer-4 checksum engine
// Lane control and lane sum records, header byte offsets, protocol codes and
// the one's-complement finishing step.
// ----------------------------------------------------------------------------
package ilce_pkg;

   // default number of bytes in one packet word
   localparam int unsigned WORD_BYTES_DEF = 4;

   // IPv4 header byte offsets
   localparam logic [15:0] OFF_VER_IHL   = 16'd0;
   localparam logic [15:0] OFF_LEN_HI    = 16'd2;
   localparam logic [15:0] OFF_LEN_LO    = 16'd3;
   localparam logic [15:0] OFF_PROTO     = 16'd9;
   localparam logic [15:0] OFF_ADDR_LO   = 16'd12;
   localparam logic [15:0] OFF_ADDR_HI   = 16'd19;
   // bytes that always count, before total length is known
   localparam logic [15:0] LEN_KNOWN_AT  = 16'd4;
   localparam logic [15:0] OFFSET_SAT    = 16'hFFFF;

   // protocol numbers
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   typedef enum logic [1:0] {
      L4_UDP   = 2'd0,
      L4_TCP   = 2'd1,
      L4_OTHER = 2'd2
   } l4_kind_type;

   // per-lane view of one byte with the header fields as seen at that byte
   typedef struct packed {
      logic        valid;
      logic [15:0] off;
      logic [7:0]  data;
      logic [5:0]  hdr_len;
      logic [15:0] pkt_len;
   } lane_ctl_type;

   // per-lane contribution: header part and layer-4 part (data + address)
   typedef struct packed {
      logic [15:0] hdr;
      logic [16:0] pay;
   } lane_sum_type;

   // packet-end information for the pseudo-header and status
   typedef struct packed {
      logic [7:0]  protocol;
      logic [15:0] l4_len;
      logic        short_pkt;
   } pkt_end_type;

   // invert a folded sum; a zero result is sent as all ones
   function automatic logic [15:0] oc_final(input logic [15:0] s);
      logic [15:0] r;
      r = ~s;
      return (r == 16'h0000) ? 16'hFFFF : r;
   endfunction

   function automatic l4_kind_type proto_kind(input logic [7:0] proto);
      l4_kind_type k;
      case (proto)
         PROTO_UDP: k = L4_UDP;
         PROTO_TCP: k = L4_TCP;
         default:   k = L4_OTHER;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/ilce_if.sv =====
// ----------------------------------------------------------------------------
// ilce_if: valid/ready channels of the checksum engine
// Request channel carries packet words, response channel carries checksums.
// ----------------------------------------------------------------------------
interface ilce_req_if #(
   parameter int unsigned WORD_BYTES = ilce_pkg::WORD_BYTES_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic [8*WORD_BYTES-1:0]               data_word;
   logic [$clog2(WORD_BYTES+1)-1:0]       byte_count;
   logic                                  last;

   modport source (output valid, data_word, byte_count, last, input ready);
   modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface ilce_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] ip_cksum;
   logic [15:0] l4_cksum;
   logic [1:0]  l4_kind;
   logic        short_packet;

   modport source (output valid, ip_cksum, l4_cksum, l4_kind, short_packet,
                   input ready);
   modport sink   (input valid, ip_cksum, l4_cksum, l4_kind, short_packet,
                   output ready);
endinterface

// ===== rtl/ilce_track.sv =====
// ----------------------------------------------------------------------------
// ilce_track: byte offset and header field tracker
// Gives each lane its byte, its offset and the header length / total length
// in force at that byte; keeps the packet state across words.
// ----------------------------------------------------------------------------
module ilce_track #(
   parameter int unsigned WORD_BYTES = ilce_pkg::WORD_BYTES_DEF,
   localparam int unsigned CNT_W = $clog2(WORD_BYTES + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [8*WORD_BYTES-1:0]                data_word,
   input  logic [CNT_W-1:0]                       byte_count,
   input  logic                                   last,
   output ilce_pkg::lane_ctl_type [WORD_BYTES-1:0] lane_ctl,
   output ilce_pkg::pkt_end_type                  pkt_end
);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WORD_BYTES);

   logic [15:0] byte_offset_ff, byte_offset_in;
   logic [5:0]  header_bytes_ff, header_bytes_in;
   logic [15:0] packet_length_ff, packet_length_in;
   logic [7:0]  protocol_ff, protocol_in;

   logic [CNT_W-1:0] cnt_eff;
   logic [5:0]       hb_work;
   logic [15:0]      pl_work;
   logic [7:0]       proto_work;
   logic [16:0]      off_end;
   logic [15:0]      off_next;

   // lane fan-out with forwarding of header fields captured in this word
   always_comb begin
      logic [16:0] off_sum;
      logic [15:0] off_lane;
      logic [7:0]  byte_lane;
      logic        vld_lane;

      cnt_eff    = (byte_count > CNT_MAX) ? CNT_MAX : byte_count;
      hb_work    = header_bytes_ff;
      pl_work    = packet_length_ff;
      proto_work = protocol_ff;
      for (int i = 0; i < WORD_BYTES; i++) begin
         off_sum   = {1'b0, byte_offset_ff} + 17'(i);
         off_lane  = off_sum[16] ? ilce_pkg::OFFSET_SAT : off_sum[15:0];
         byte_lane = data_word[8*(WORD_BYTES-1-i) +: 8];
         vld_lane  = (CNT_W'(i) < cnt_eff);
         if (vld_lane) begin
            if (off_lane == ilce_pkg::OFF_VER_IHL) hb_work = {byte_lane[3:0], 2'b00};
            if (off_lane == ilce_pkg::OFF_LEN_HI)  pl_work[15:8] = byte_lane;
            if (off_lane == ilce_pkg::OFF_LEN_LO)  pl_work[7:0]  = byte_lane;
            if (off_lane == ilce_pkg::OFF_PROTO)   proto_work = byte_lane;
         end
         lane_ctl[i].valid   = vld_lane;
         lane_ctl[i].off     = off_lane;
         lane_ctl[i].data    = byte_lane;
         lane_ctl[i].hdr_len = hb_work;
         lane_ctl[i].pkt_len = pl_work;
      end
   end

   // offset after this word, saturating
   assign off_end  = {1'b0, byte_offset_ff} + 17'(cnt_eff);
   assign off_next = off_end[16] ? ilce_pkg::OFFSET_SAT : off_end[15:0];

   // packet-end values for the pseudo-header and status
   assign pkt_end.protocol  = proto_work;
   assign pkt_end.l4_len    = pl_work - {10'b0, hb_work};
   assign pkt_end.short_pkt = (off_next < ilce_pkg::LEN_KNOWN_AT) || (off_next < pl_work);

   // next state: back to zero after the last word
   always_comb begin
      byte_offset_in   = byte_offset_ff;
      header_bytes_in  = header_bytes_ff;
      packet_length_in = packet_length_ff;
      protocol_in      = protocol_ff;
      if (accept) begin
         if (last) begin
            byte_offset_in   = '0;
            header_bytes_in  = '0;
            packet_length_in = '0;
            protocol_in      = '0;
         end else begin
            byte_offset_in   = off_next;
            header_bytes_in  = hb_work;
            packet_length_in = pl_work;
            protocol_in      = proto_work;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff   <= '0;
         header_bytes_ff  <= '0;
         packet_length_ff <= '0;
         protocol_ff      <= '0;
      end else begin
         byte_offset_ff   <= byte_offset_in;
         header_bytes_ff  <= header_bytes_in;
         packet_length_ff <= packet_length_in;
         protocol_ff      <= protocol_in;
      end
   end

endmodule

// ===== rtl/ilce_lane.sv =====
// ----------------------------------------------------------------------------
// ilce_lane: one byte lane of the checksum engine
// Places the byte in the high or low half of a 16-bit column and routes it
// to the header sum or the layer-4 sum; address bytes also go to layer 4.
// ----------------------------------------------------------------------------
module ilce_lane (
   input  ilce_pkg::lane_ctl_type ctl,
   output ilce_pkg::lane_sum_type sum
);

   logic [15:0] lane_val;
   logic        addr_hit;
   logic        in_pkt;
   logic        hdr_hit;

   // even offsets are the high byte of a 16-bit word
   assign lane_val = ctl.off[0] ? {8'h00, ctl.data} : {ctl.data, 8'h00};

   // source and destination addresses feed the pseudo-header
   assign addr_hit = ctl.valid
                   && (ctl.off inside {[ilce_pkg::OFF_ADDR_LO:ilce_pkg::OFF_ADDR_HI]});

   // bytes past the total length are dropped
   assign in_pkt  = ctl.valid && ((ctl.off < ilce_pkg::LEN_KNOWN_AT) || (ctl.off < ctl.pkt_len));
   assign hdr_hit = in_pkt && (ctl.off < {10'b0, ctl.hdr_len});

   assign sum.hdr = hdr_hit ? lane_val : 16'h0000;
   assign sum.pay = (addr_hit ? {1'b0, lane_val} : 17'd0)
                  + ((in_pkt && !hdr_hit) ? {1'b0, lane_val} : 17'd0);

endmodule

// ===== rtl/ilce_merge.sv =====
// ----------------------------------------------------------------------------
// ilce_merge: lane merge, accumulators and result register
// Registers the lane sums, adds them into the folded header and layer-4
// sums, and on the last word finishes both checksums into the output stage.
// ----------------------------------------------------------------------------
module ilce_merge #(
   parameter int unsigned WORD_BYTES = ilce_pkg::WORD_BYTES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic                                   req_last,
   input  ilce_pkg::lane_sum_type [WORD_BYTES-1:0] lane_sum,
   input  ilce_pkg::pkt_end_type                  pkt_end,
   output logic                                   req_ready,
   ilce_rsp_if.source                             rsp_if
);

   // room for the accumulator, all lane parts, protocol and length
   localparam int unsigned SUM_W = 16 + $clog2(2*WORD_BYTES + 4);

   // merge stage
   logic                                   s1_valid_ff, s1_valid_in;
   logic                                   s1_last_ff, s1_last_in;
   ilce_pkg::lane_sum_type [WORD_BYTES-1:0] s1_sum_ff;
   ilce_pkg::pkt_end_type                  s1_end_ff;

   // running folded sums
   logic [15:0] hdr_acc_ff, hdr_acc_in;
   logic [15:0] pay_acc_ff, pay_acc_in;

   // output stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           ip_ff, l4_ff;
   ilce_pkg::l4_kind_type kind_ff;
   logic                  short_ff;

   logic             advance;
   logic             merge_en;
   logic             finish;
   logic [SUM_W-1:0] hdr_wide, pay_wide;
   logic [16:0]      hdr_f1, pay_f1;
   logic [15:0]      hdr_fold, pay_fold;

   // the merge stage only waits when it holds a result and the output is full
   assign advance   = !(s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_if.ready);
   assign req_ready = advance;
   assign merge_en  = s1_valid_ff && advance;
   assign finish    = merge_en && s1_last_ff;

   assign s1_valid_in = advance ? accept : s1_valid_ff;
   assign s1_last_in  = accept ? req_last : s1_last_ff;

   // add all lanes into the accumulators; pseudo-header tail on the last word
   always_comb begin
      hdr_wide = SUM_W'(hdr_acc_ff);
      pay_wide = SUM_W'(pay_acc_ff);
      for (int i = 0; i < WORD_BYTES; i++) begin
         hdr_wide = hdr_wide + SUM_W'(s1_sum_ff[i].hdr);
         pay_wide = pay_wide + SUM_W'(s1_sum_ff[i].pay);
      end
      if (s1_last_ff) begin
         pay_wide = pay_wide + SUM_W'(s1_end_ff.protocol) + SUM_W'(s1_end_ff.l4_len);
      end
   end

   // end-around carry, two folds
   assign hdr_f1   = {1'b0, hdr_wide[15:0]} + 17'(hdr_wide[SUM_W-1:16]);
   assign pay_f1   = {1'b0, pay_wide[15:0]} + 17'(pay_wide[SUM_W-1:16]);
   assign hdr_fold = hdr_f1[15:0] + 16'(hdr_f1[16]);
   assign pay_fold = pay_f1[15:0] + 16'(pay_f1[16]);

   always_comb begin
      hdr_acc_in = hdr_acc_ff;
      pay_acc_in = pay_acc_ff;
      if (merge_en) begin
         hdr_acc_in = s1_last_ff ? 16'h0000 : hdr_fold;
         pay_acc_in = s1_last_ff ? 16'h0000 : pay_fold;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;
      if (finish) rsp_valid_in = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         hdr_acc_ff   <= '0;
         pay_acc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_last_ff   <= s1_last_in;
         hdr_acc_ff   <= hdr_acc_in;
         pay_acc_ff   <= pay_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sum_ff <= lane_sum;
         s1_end_ff <= pkt_end;
      end
      if (finish) begin
         ip_ff    <= ilce_pkg::oc_final(hdr_fold);
         l4_ff    <= ilce_pkg::oc_final(pay_fold);
         kind_ff  <= ilce_pkg::proto_kind(s1_end_ff.protocol);
         short_ff <= s1_end_ff.short_pkt;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.ip_cksum     = ip_ff;
   assign rsp_if.l4_cksum     = l4_ff;
   assign rsp_if.l4_kind      = kind_ff;
   assign rsp_if.short_packet = short_ff;

endmodule

// ===== rtl/ipv4_l4_checksum_engine_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_l4_checksum_engine_core: IPv4 header and TCP/UDP checksum engine
// Packet words enter on req_if, one checksum result per packet leaves on
// rsp_if.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries the packet from the first IP header byte, big-endian,
//    byte_count valid bytes from the top of the word, last on the final word.
//  - rsp_if gives one result per packet: header checksum, layer-4 checksum
//    over pseudo-header and payload (zero sent as 0xFFFF), protocol kind, and
//    a flag for a packet that ended before its total length.
//  - Throughput: one word per clock. Each word is split over WORD_BYTES byte
//    lanes working in parallel; a merge stage adds the lanes into the sums.
//  - Result path: a last word passes one merge stage plus the output register
//    before its result shows on rsp_if.
//  - Reset clears the packet state, the sums and both stages; rsp_if is idle.
//  - Stall: a finished result waits in the output register while words of the
//    next packet keep flowing; req_if.ready drops only when the next packet's
//    last word has reached the merge stage and the output is still full.
// ----------------------------------------------------------------------------
module ipv4_l4_checksum_engine_core #(
   parameter int unsigned WORD_BYTES = ilce_pkg::WORD_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   ilce_req_if.sink   req_if,
   ilce_rsp_if.source rsp_if
);

   logic                                   accept;
   logic                                   req_ready;
   ilce_pkg::lane_ctl_type [WORD_BYTES-1:0] lane_ctl;
   ilce_pkg::lane_sum_type [WORD_BYTES-1:0] lane_sum;
   ilce_pkg::pkt_end_type                  pkt_end;

   assign accept       = req_if.valid && req_ready;
   assign req_if.ready = req_ready;

   // offset and header field tracking
   ilce_track #(.WORD_BYTES(WORD_BYTES)) u_track (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_word  (req_if.data_word),
      .byte_count (req_if.byte_count),
      .last       (req_if.last),
      .lane_ctl   (lane_ctl),
      .pkt_end    (pkt_end)
   );

   // byte lanes
   for (genvar g = 0; g < WORD_BYTES; g++) begin : g_lane
      ilce_lane u_lane (
         .ctl (lane_ctl[g]),
         .sum (lane_sum[g])
      );
   end

   // merge, accumulate and finish
   ilce_merge #(.WORD_BYTES(WORD_BYTES)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_last  (req_if.last),
      .lane_sum  (lane_sum),
      .pkt_end   (pkt_end),
      .req_ready (req_ready),
      .rsp_if    (rsp_if)
   );

   // no result straight out of reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result valid right after reset");

   // finished checksums are never zero
   a_cksum_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.ip_cksum != 16'h0000) && (rsp_if.l4_cksum != 16'h0000))
      else $error("zero checksum sent");

   // an accepted last word leads to a pending result
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.last) |-> ##2 rsp_if.valid)
      else $error("no result after last word");

   // the input is only held back while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_if.valid && !rsp_if.ready))
      else $error("input stalled without a waiting result");

endmodule

// ===== tb/sv/ipv4_l4_checksum_engine_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_l4_checksum_engine_core_tb: self-checking bench of the checksum engine
// Drives IPv4 packets as 32-bit words (directed corner packets, then random
// well-formed, truncated, malformed and noise packets). A local model folds
// every accepted word into header and layer-4 sums and queues one expected
// result per packet. The response monitor compares each transfer against the
// oldest queued result. Both sides idle at random; the response side holds
// off once long enough to stall the input.
// ----------------------------------------------------------------------------
module ipv4_l4_checksum_engine_core_tb;

   localparam int unsigned WORD_BYTES   = 4;
   localparam int          RANDOM_WORDS = 800;
   localparam int          IDLE_PCT     = 29;
   localparam int          HOLD_CYCLES  = 200;
   localparam int          QUIET_LIMIT  = 2000;
   localparam int          TAIL_CYCLES  = 16;
   // cycle windows with no random idling on either side
   localparam int unsigned SEND_FREE_LO = 250;
   localparam int unsigned SEND_FREE_HI = 650;
   localparam int unsigned RSP_FREE_LO  = 400;
   localparam int unsigned RSP_FREE_HI  = 800;
   // checksum field offsets
   localparam int IP_CK_AT  = 10;
   localparam int UDP_CK_AT = 6;
   localparam int TCP_CK_AT = 16;

   typedef enum int {CK_RANDOM, CK_ZERO, CK_VALID} ck_mode_type;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  count;
      logic        last;
      logic        wait_drain;
      logic        start_hold;
   } word_item_type;

   typedef struct packed {
      logic [15:0]           ip_cksum;
      logic [15:0]           l4_cksum;
      ilce_pkg::l4_kind_type l4_kind;
      logic                  short_packet;
   } checksum_rec_type;

   logic clock;
   logic reset;

   ilce_req_if #(.WORD_BYTES(WORD_BYTES)) req_if ();
   ilce_rsp_if                            rsp_if ();

   ipv4_l4_checksum_engine_core #(
      .WORD_BYTES(WORD_BYTES)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // stimulus and expectation stores
   word_item_type    pending_words[$];
   checksum_rec_type cksum_due[$];
   logic [7:0]       pkt_buf[$];

   int          words_in    = 0;
   int          total_words = 0;
   int          mismatches  = 0;
   int unsigned cyc         = 0;
   int          quiet       = 0;
   int          hold_left   = 0;
   logic        hold_used   = 1'b0;
   logic        hold_req    = 1'b0;

   word_item_type    drv_word;
   logic             drv_busy;
   checksum_rec_type mon_due;

   // running packet state of the local model
   logic [15:0] run_off;
   logic [15:0] hdr_sum;
   logic [15:0] l4_sum;
   logic [5:0]  hdr_len;
   logic [15:0] tot_len;
   logic [7:0]  proto_seen;

   // 16-bit one's-complement add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + 16'(s[16]);
   endfunction

   task automatic clear_packet_state();
      run_off    = '0;
      hdr_sum    = '0;
      l4_sum     = '0;
      hdr_len    = '0;
      tot_len    = '0;
      proto_seen = '0;
   endtask

   // one packet byte at offset off
   task automatic sum_packet_byte(input logic [15:0] off, input logic [7:0] v);
      logic [15:0] lane;
      lane = off[0] ? {8'h00, v} : {v, 8'h00};
      if (off == ilce_pkg::OFF_VER_IHL)
         hdr_len = {v[3:0], 2'b00};
      else if (off == ilce_pkg::OFF_LEN_HI)
         tot_len[15:8] = v;
      else if (off == ilce_pkg::OFF_LEN_LO)
         tot_len[7:0] = v;
      else if (off == ilce_pkg::OFF_PROTO)
         proto_seen = v;
      // addresses always go into the pseudo-header
      if (off >= ilce_pkg::OFF_ADDR_LO && off <= ilce_pkg::OFF_ADDR_HI)
         l4_sum = ones_add(l4_sum, lane);
      // bytes past total length are dropped, first four always count
      if (off < ilce_pkg::LEN_KNOWN_AT || off < tot_len) begin
         if (off < {10'd0, hdr_len})
            hdr_sum = ones_add(hdr_sum, lane);
         else
            l4_sum = ones_add(l4_sum, lane);
      end
   endtask

   // fold one accepted word; on last, queue the expected result
   task automatic fold_packet_word(input word_item_type w);
      int               n;
      logic [15:0]      l4_len;
      logic [15:0]      s;
      logic [15:0]      r;
      checksum_rec_type res;
      n = (w.count > WORD_BYTES) ? WORD_BYTES : w.count;
      for (int i = 0; i < n; i++) begin
         sum_packet_byte(run_off, w.data[31-8*i -: 8]);
         if (run_off != ilce_pkg::OFFSET_SAT)
            run_off++;
      end
      if (w.last) begin
         l4_len = tot_len - {10'd0, hdr_len};
         s = ones_add(l4_sum, {8'h00, proto_seen});
         s = ones_add(s, l4_len);
         r = ~hdr_sum;
         res.ip_cksum = (r == 16'h0000) ? 16'hFFFF : r;
         r = ~s;
         res.l4_cksum = (r == 16'h0000) ? 16'hFFFF : r;
         if (proto_seen == ilce_pkg::PROTO_UDP)
            res.l4_kind = ilce_pkg::L4_UDP;
         else if (proto_seen == ilce_pkg::PROTO_TCP)
            res.l4_kind = ilce_pkg::L4_TCP;
         else
            res.l4_kind = ilce_pkg::L4_OTHER;
         res.short_packet = (run_off < ilce_pkg::LEN_KNOWN_AT) || (run_off < tot_len);
         cksum_due.push_back(res);
         clear_packet_state();
      end
   endtask

   task automatic set_byte(input int idx, input logic [7:0] v);
      if (idx < pkt_buf.size())
         pkt_buf[idx] = v;
   endtask

   // IPv4 packet of n_bytes random bytes with the main header fields filled in
   task automatic build_ip(input int ihl, input int tot, input logic [7:0] proto,
                           input int n_bytes, input ck_mode_type ck_mode);
      int          hlen;
      logic [15:0] s;
      hlen = ihl * 4;
      pkt_buf.delete();
      for (int i = 0; i < n_bytes; i++)
         pkt_buf.push_back(8'($urandom));
      set_byte(0, {4'h4, 4'(ihl)});
      set_byte(2, 8'(tot >> 8));
      set_byte(3, 8'(tot));
      set_byte(9, proto);
      if (ck_mode != CK_RANDOM) begin
         set_byte(IP_CK_AT, 8'h00);
         set_byte(IP_CK_AT + 1, 8'h00);
         if (proto == ilce_pkg::PROTO_UDP) begin
            set_byte(hlen + UDP_CK_AT, 8'h00);
            set_byte(hlen + UDP_CK_AT + 1, 8'h00);
         end else if (proto == ilce_pkg::PROTO_TCP) begin
            set_byte(hlen + TCP_CK_AT, 8'h00);
            set_byte(hlen + TCP_CK_AT + 1, 8'h00);
         end
      end
      // correct header checksum: the header then sums to all ones
      if (ck_mode == CK_VALID && hlen >= IP_CK_AT + 2 && hlen <= n_bytes) begin
         s = '0;
         for (int i = 0; i < hlen; i += 2)
            s = ones_add(s, {pkt_buf[i], pkt_buf[i+1]});
         set_byte(IP_CK_AT, ~s[15:8]);
         set_byte(IP_CK_AT + 1, ~s[7:0]);
      end
   endtask

   // split pkt_buf into words; odd mode mixes in empty, partial and oversized counts
   task automatic queue_packet(input bit drain, input bit hold, input bit odd, input bit junk);
      int            pos;
      int            n;
      int            take;
      bit            first;
      word_item_type w;
      pos   = 0;
      n     = pkt_buf.size();
      first = 1'b1;
      do begin
         w.data = junk ? $urandom : 32'h0;
         take   = n - pos;
         if (take > WORD_BYTES)
            take = WORD_BYTES;
         w.count = 3'(take);
         if (odd) begin
            case ($urandom_range(7))
               0: begin
                  take    = 0;
                  w.count = 3'd0;
               end
               1: if (take == WORD_BYTES)
                  w.count = 3'($urandom_range(WORD_BYTES + 1, 7));
               2: if (take > 1) begin
                  take    = $urandom_range(1, take - 1);
                  w.count = 3'(take);
               end
               default: ;
            endcase
         end
         for (int i = 0; i < take; i++)
            w.data[31-8*i -: 8] = pkt_buf[pos+i];
         pos          += take;
         w.last       = (pos >= n);
         w.wait_drain = drain && first;
         w.start_hold = hold && first;
         first        = 1'b0;
         pending_words.push_back(w);
      end while (pos < n);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle count and watchdog on lack of transfers
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // long response hold-off, started once by the driver
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_req && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // request driver: model update on each transfer, then offer the next word
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         hold_req     <= 1'b0;
         drv_busy = 1'b0;
         clear_packet_state();
      end else begin
         if (req_if.valid && req_if.ready) begin
            fold_packet_word(drv_word);
            words_in <= words_in + 1;
            drv_busy = 1'b0;
         end
         if (!drv_busy && pending_words.size() != 0 &&
             (!pending_words[0].wait_drain || cksum_due.size() == 0) &&
             ((cyc >= SEND_FREE_LO && cyc < SEND_FREE_HI) ||
              $urandom_range(99) >= IDLE_PCT)) begin
            drv_word = pending_words.pop_front();
            drv_busy = 1'b1;
            if (drv_word.start_hold)
               hold_req <= 1'b1;
         end
         req_if.valid      <= drv_busy;
         req_if.data_word  <= drv_word.data;
         req_if.byte_count <= drv_word.count;
         req_if.last       <= drv_word.last;
      end
   end

   // response monitor and ready generation
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (cksum_due.size() == 0) begin
               $error("result transfer with no packet outstanding");
               mismatches++;
            end else begin
               mon_due = cksum_due.pop_front();
               if (rsp_if.ip_cksum !== mon_due.ip_cksum) begin
                  $error("ip_cksum mismatch: expected %h, got %h",
                         mon_due.ip_cksum, rsp_if.ip_cksum);
                  mismatches++;
               end
               if (rsp_if.l4_cksum !== mon_due.l4_cksum) begin
                  $error("l4_cksum mismatch: expected %h, got %h",
                         mon_due.l4_cksum, rsp_if.l4_cksum);
                  mismatches++;
               end
               if (rsp_if.l4_kind !== mon_due.l4_kind) begin
                  $error("l4_kind mismatch: expected %0d, got %0d",
                         mon_due.l4_kind, rsp_if.l4_kind);
                  mismatches++;
               end
               if (rsp_if.short_packet !== mon_due.short_packet) begin
                  $error("short_packet mismatch: expected %b, got %b",
                         mon_due.short_packet, rsp_if.short_packet);
                  mismatches++;
               end
            end
         end
         rsp_if.ready <= (hold_left == 0) &&
                         ((cyc >= RSP_FREE_LO && cyc < RSP_FREE_HI) ||
                          $urandom_range(99) >= IDLE_PCT);
      end
   end

   // stimulus build, reset and end of run
   initial begin
      int         pkt_no;
      int         pick;
      int         ihl;
      int         tot;
      int         n;
      logic [7:0] proto;
      bit         drain;
      bit         hold;
      bit         odd;

      reset = 1'b1;

      // directed: all-ones word with a huge length, so the packet is short
      pkt_buf.delete();
      repeat (4) pkt_buf.push_back(8'hFF);
      queue_packet(1'b1, 1'b0, 1'b0, 1'b0);
      // empty packet: zero byte count on the last word
      pkt_buf.delete();
      queue_packet(1'b1, 1'b0, 1'b0, 1'b0);
      // single zero byte
      pkt_buf.push_back(8'h00);
      queue_packet(1'b1, 1'b0, 1'b0, 1'b0);
      // UDP with a correct header checksum and two bytes past total length
      build_ip(5, 28, ilce_pkg::PROTO_UDP, 30, CK_VALID);
      queue_packet(1'b1, 1'b0, 1'b0, 1'b1);
      // TCP with an odd trailing payload byte and irregular byte counts
      build_ip(5, 21, ilce_pkg::PROTO_TCP, 21, CK_ZERO);
      queue_packet(1'b1, 1'b0, 1'b1, 1'b1);
      // header only, some other protocol
      build_ip(5, 20, 8'd1, 20, CK_RANDOM);
      queue_packet(1'b1, 1'b0, 1'b0, 1'b1);
      // largest header length with a total length below it
      build_ip(15, 8, ilce_pkg::PROTO_UDP, 12, CK_RANDOM);
      queue_packet(1'b1, 1'b0, 1'b0, 1'b1);

      // random packets: mostly well formed, some cut short, malformed or noise
      n      = pending_words.size() + RANDOM_WORDS;
      pkt_no = 0;
      while (pending_words.size() < n) begin
         drain = (pkt_no % 16 == 5) && !(pkt_no >= 36 && pkt_no <= 52);
         hold  = (pkt_no == 40);
         pick  = $urandom_range(99);
         if (pick < 85) begin
            ihl = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
            tot = ihl * 4 + (($urandom_range(9) == 0) ? $urandom_range(65, 300)
                                                      : $urandom_range(0, 64));
            case ($urandom_range(9))
               0, 1, 2, 3: proto = ilce_pkg::PROTO_TCP;
               4, 5, 6, 7: proto = ilce_pkg::PROTO_UDP;
               default:    proto = 8'($urandom);
            endcase
            if (pick >= 70)
               build_ip(ihl, tot, proto, $urandom_range(0, tot - 1),
                        ck_mode_type'($urandom_range(2)));
            else
               build_ip(ihl, tot, proto,
                        tot + (($urandom_range(4) == 0) ? $urandom_range(1, 7) : 0),
                        ck_mode_type'($urandom_range(2)));
            odd = ($urandom_range(9) == 0);
         end else if (pick < 95) begin
            build_ip($urandom_range(15), $urandom_range(100), 8'($urandom),
                     $urandom_range(80), CK_RANDOM);
            odd = ($urandom_range(2) == 0);
         end else begin
            pkt_buf.delete();
            repeat ($urandom_range(40)) pkt_buf.push_back(8'($urandom));
            odd = 1'b1;
         end
         queue_packet(drain, hold, odd, 1'b1);
         pkt_no++;
      end
      total_words = pending_words.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (words_in != total_words)
         @(posedge clock);
      while (cksum_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
